[sv/ftdt_pkg.sv]
// ftdt_pkg: shared types and constants for the float to decimal text block.
// Used by ftdt_ctrl, ftdt_datapath and float_to_decimal_text_top; no dependencies.
package ftdt_pkg;

    // ASCII characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_N_UP  = 8'h4E;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_I_LO  = 8'h69;
    localparam logic [7:0] CH_N_LO  = 8'h6E;
    localparam logic [7:0] CH_F_LO  = 8'h66;

    // single-precision fields
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_SAT     = 8'd158;   // magnitude 2^31 and up
    localparam logic [7:0] EXP_INT     = 8'd150;   // mantissa is integer at this exponent
    localparam logic [7:0] SUBN_SHIFT  = 8'd149;
    localparam int         MAN_W       = 24;

    // integer part conversion: 32-bit binary to ten BCD digits, two bits a step
    localparam int BIN_W      = 32;
    localparam int INT_DIGITS = 10;
    localparam int BCD_W      = 4 * INT_DIGITS;
    localparam int DD_STEPS   = BIN_W / 2;
    localparam logic [BIN_W-1:0] INT_SAT = 32'h7FFF_FFFF;

    // precision register
    localparam int         PREC_W     = 4;
    localparam logic [3:0] PREC_RESET = 4'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_CONV,
        S_LEN,
        S_SIGN,
        S_INT,
        S_DOT,
        S_FRAC,
        S_SPEC
    } t_state;

    // output character source
    typedef enum logic [2:0] {
        SEL_MINUS,
        SEL_INT,
        SEL_DOT,
        SEL_FRAC,
        SEL_SPEC
    } t_sel;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       len_load;
        logic       int_next;
        logic       frac_step;
        logic       emit;
        logic       last;
        t_sel       sel;
        logic [1:0] spec_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic       nan;
        logic       inf;
        logic       zero;
        logic       neg;
        logic [3:0] int_rem;
        logic [1:0] spec_len;
    } t_dp_stat;

    // fixed text for NaN, infinity and zero
    function automatic logic [7:0] spec_char(logic nan, logic inf, logic [1:0] idx);
        logic [7:0] c;
        c = CH_ZERO;
        if (nan) begin
            c = (idx == 2'd1) ? CH_A_LO : CH_N_UP;
        end else if (inf) begin
            unique case (idx)
                2'd0:    c = CH_I_LO;
                2'd1:    c = CH_N_LO;
                default: c = CH_F_LO;
            endcase
        end
        return c;
    endfunction

endpackage

[sv/ftdt_datapath.sv]
// ftdt_datapath: unpacking, BCD conversion, fraction digits and output register.
// Depends on ftdt_pkg; driven by ftdt_ctrl through t_dp_cmd.
module ftdt_datapath
    import ftdt_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_value_bits,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_char_valid,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic        o_overflow
);

    localparam int FB = FRACTION_BITS;
    localparam int FW = MAN_W + FB;

    logic                    r_neg, r_nan, r_inf, r_zero, r_ovf;
    logic [BIN_W-1:0]        r_bin;
    logic [BCD_W-1:0]        r_bcd;
    logic [FB-1:0]           r_frac;
    logic [3:0]              r_int_rem;
    logic                    r_valid;
    logic [7:0]              r_char;
    logic                    r_last;
    logic                    r_out_ovf;

    // two double-dabble iterations
    function automatic logic [BCD_W+BIN_W-1:0] dd_two(logic [BCD_W+BIN_W-1:0] v);
        logic [BCD_W+BIN_W-1:0] t;
        t = v;
        for (int s = 0; s < 2; s++) begin
            for (int d = 0; d < INT_DIGITS; d++) begin
                if (t[BIN_W+4*d +: 4] >= 4'd5)
                    t[BIN_W+4*d +: 4] = t[BIN_W+4*d +: 4] + 4'd3;
            end
            t = t << 1;
        end
        return t;
    endfunction

    // unpack the incoming word
    logic [7:0]        u_ex;
    logic [22:0]       u_man;
    logic [MAN_W-1:0]  u_m;
    logic [MAN_W-1:0]  u_rem;
    logic [7:0]        u_sh;
    logic [2:0]        u_shl;
    logic [FW-1:0]     u_fw;
    logic [BIN_W-1:0]  u_ipart;
    logic [FB-1:0]     u_frac;
    logic              u_ovf;

    always_comb begin
        u_ex    = i_value_bits[30:23];
        u_man   = i_value_bits[22:0];
        u_m     = (u_ex == 8'd0) ? {1'b0, u_man} : {1'b1, u_man};
        u_sh    = (u_ex == 8'd0) ? SUBN_SHIFT : (EXP_INT - u_ex);
        u_shl   = 3'(u_ex - EXP_INT);
        u_rem   = u_m & ~({MAN_W{1'b1}} << u_sh);
        u_fw    = {u_rem, {FB{1'b0}}} >> u_sh;
        u_ovf   = 1'b0;
        u_frac  = '0;
        u_ipart = '0;
        if (u_ex >= EXP_SAT) begin
            u_ovf   = (u_ex != EXP_SPECIAL);
            u_ipart = INT_SAT;
        end else if (u_ex >= EXP_INT) begin
            u_ipart = BIN_W'(u_m) << u_shl;
        end else begin
            u_ipart = BIN_W'(u_m >> u_sh);
            u_frac  = u_fw[FB-1:0];
        end
    end

    // leading digit count of the BCD integer part
    logic [3:0] len_nd;
    always_comb begin
        len_nd = 4'd0;
        for (int d = 0; d < INT_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0)
                len_nd = 4'(d + 1);
        end
    end

    // current integer digit
    logic [3:0] int_dig;
    always_comb begin
        int_dig = 4'd0;
        for (int d = 0; d < INT_DIGITS; d++) begin
            if (r_int_rem == 4'(d + 1))
                int_dig = r_bcd[4*d +: 4];
        end
    end

    // fraction times ten
    logic [FB+3:0] fr_p;
    logic [3:0]    fr_dig;
    always_comb begin
        fr_p   = ({4'd0, r_frac} << 3) + ({4'd0, r_frac} << 1);
        fr_dig = (fr_p[FB+3:FB] > 4'd9) ? 4'd9 : fr_p[FB+3:FB];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value_bits[31];
            r_nan  <= (u_ex == EXP_SPECIAL) && (u_man != 23'd0);
            r_inf  <= (u_ex == EXP_SPECIAL) && (u_man == 23'd0);
            r_zero <= (u_ex == 8'd0) && (u_man == 23'd0);
            r_ovf  <= u_ovf;
            r_bin  <= u_ipart;
            r_bcd  <= '0;
            r_frac <= u_frac;
        end
        if (i_cmd.conv_step)
            {r_bcd, r_bin} <= dd_two({r_bcd, r_bin});
        if (i_cmd.len_load)
            r_int_rem <= len_nd;
        if (i_cmd.int_next)
            r_int_rem <= r_int_rem - 4'd1;
        if (i_cmd.frac_step)
            r_frac <= fr_p[FB-1:0];
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last    <= i_cmd.last;
            r_out_ovf <= r_ovf;
            unique case (i_cmd.sel)
                SEL_MINUS: r_char <= CH_MINUS;
                SEL_INT:   r_char <= CH_ZERO + {4'd0, int_dig};
                SEL_DOT:   r_char <= CH_DOT;
                SEL_FRAC:  r_char <= CH_ZERO + {4'd0, fr_dig};
                SEL_SPEC:  r_char <= spec_char(r_nan, r_inf, i_cmd.spec_idx);
                default:   r_char <= CH_DOT;
            endcase
        end
    end

    assign o_stat.nan      = r_nan;
    assign o_stat.inf      = r_inf;
    assign o_stat.zero     = r_zero;
    assign o_stat.neg      = r_neg;
    assign o_stat.int_rem  = r_int_rem;
    assign o_stat.spec_len = r_zero ? 2'd1 : 2'd3;

    assign o_char_valid = r_valid;
    assign o_text_char  = r_char;
    assign o_last_char  = r_last;
    assign o_overflow   = r_out_ovf;

endmodule

[sv/ftdt_ctrl.sv]
// ftdt_ctrl: sequencer and precision register for the float to decimal text block.
// Depends on ftdt_pkg; commands ftdt_datapath through t_dp_cmd.
module ftdt_ctrl
    import ftdt_pkg::*;
#(
    parameter int MAX_PRECISION = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_valid,
    input  logic [PREC_W-1:0] i_cfg_data,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    localparam int PW    = $clog2(MAX_PRECISION + 1);
    localparam int CNT_W = (PW > 4) ? PW : 4;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PREC_W-1:0] r_prec;
    logic [PW-1:0]     prec_eff;
    t_dp_cmd           cmd;

    // precision register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= PREC_RESET;
        end else if (i_cfg_valid) begin
            r_prec <= i_cfg_data;
        end
    end

    assign prec_eff = (32'(r_prec) > MAX_PRECISION) ? PW'(MAX_PRECISION) : PW'(r_prec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        cmd          = '0;
        cmd.sel      = SEL_DOT;
        cmd.spec_idx = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                n_cnt = '0;
                priority if (i_stat.nan || i_stat.zero) begin
                    n_state = S_SPEC;
                end else if (i_stat.inf) begin
                    n_state = i_stat.neg ? S_SIGN : S_SPEC;
                end else begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                cmd.conv_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DD_STEPS - 1))
                    n_state = S_LEN;
            end
            S_LEN: begin
                cmd.len_load = 1'b1;
                n_state      = i_stat.neg ? S_SIGN : S_INT;
            end
            S_SIGN: begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_MINUS;
                n_cnt    = '0;
                n_state  = i_stat.inf ? S_SPEC : S_INT;
            end
            S_INT, S_DOT: begin
                if (r_state == S_INT && i_stat.int_rem != 4'd0) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = SEL_INT;
                    cmd.int_next = 1'b1;
                    if (i_stat.int_rem == 4'd1)
                        n_state = S_DOT;
                end else begin
                    // decimal point; ends the text at precision zero
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_DOT;
                    cmd.last = (prec_eff == '0);
                    n_cnt    = '0;
                    n_state  = (prec_eff == '0) ? S_IDLE : S_FRAC;
                end
            end
            S_FRAC: begin
                cmd.emit      = 1'b1;
                cmd.sel       = SEL_FRAC;
                cmd.frac_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(prec_eff - PW'(1))) begin
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SPEC: begin
                cmd.emit = 1'b1;
                cmd.sel  = SEL_SPEC;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt[1:0] == i_stat.spec_len - 2'd1) begin
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

[sv/float_to_decimal_text_top.sv]
// Float to decimal text converter. A number is accepted when start is high and
// busy is low; its characters then leave on o_text_char, one per cycle, each
// marked by o_char_valid for exactly one cycle, with o_last_char on the final
// one. The receiver cannot stall: every strobed word must be taken. For a
// finite nonzero value the block classifies it, converts the integer part
// from binary to BCD (two bits a cycle), counts its digits, then sends the
// characters (sign, integer digits, point, precision fraction digits). NaN,
// infinity and zero go to their characters straight after classifying. busy
// falls as the last character appears, so the next number can start right
// away. The precision register may be written at any time the block is idle;
// o_cfg_ready is high.
// Depends on ftdt_pkg, ftdt_ctrl and ftdt_datapath.
module float_to_decimal_text_top
    import ftdt_pkg::*;
#(
    parameter int FRACTION_BITS = 32,
    parameter int MAX_PRECISION = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       i_value_bits,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PREC_W-1:0] i_cfg_data,
    output logic              o_char_valid,
    output logic [7:0]        o_text_char,
    output logic              o_last_char,
    output logic              o_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ftdt_ctrl #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ftdt_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value_bits (i_value_bits),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_char_valid (o_char_valid),
        .o_text_char  (o_text_char),
        .o_last_char  (o_last_char),
        .o_overflow   (o_overflow)
    );

endmodule

[verif/ftdt_text_checker.sv]
// ftdt_text_checker: watches the number, precision and character channels of
// float_to_decimal_text_top, predicts each number's text and compares it word by word.
// Depends on ftdt_pkg for character codes and exponent constants.
`timescale 1ns / 1ps

module ftdt_text_checker
    import ftdt_pkg::*;
#(
    parameter int MAX_PRECISION = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [31:0]       i_value_bits,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [PREC_W-1:0] i_cfg_data,
    input  logic              i_char_valid,
    input  logic [7:0]        i_text_char,
    input  logic              i_last_char,
    input  logic              i_overflow,
    output int                o_fail_count,
    output int                o_pending
);

    // fixed-point fraction width used for the digit extraction
    localparam int FRAC_W = 32;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       ovf;
    } t_text_word;

    t_text_word        expected_text[$];
    t_text_word        got_word;
    logic [PREC_W-1:0] precision;
    int                fail_count = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void push_char(input logic [7:0] ch, input logic ovf);
        t_text_word w;
        w.ch      = ch;
        w.is_last = 1'b0;
        w.ovf     = ovf;
        expected_text.push_back(w);
    endfunction

    // Expected characters of one number at the current precision
    function automatic void predict_text(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [63:0] mant, rem, frac, prod;
        logic [31:0] ipart;
        logic        ovf;
        logic [3:0]  dig[INT_DIGITS];
        logic [63:0] d;
        int          e, sh, nd, prec;
        neg   = bits[31];
        ex    = bits[30:23];
        man   = bits[22:0];
        ovf   = 1'b0;
        ipart = '0;
        frac  = '0;
        nd    = 0;
        if (ex == EXP_SPECIAL) begin
            if (man != '0) begin
                push_char(CH_N_UP, 1'b0);
                push_char(CH_A_LO, 1'b0);
                push_char(CH_N_UP, 1'b0);
            end else begin
                if (neg) push_char(CH_MINUS, 1'b0);
                push_char(CH_I_LO, 1'b0);
                push_char(CH_N_LO, 1'b0);
                push_char(CH_F_LO, 1'b0);
            end
        end else if (ex == 8'd0 && man == '0) begin
            push_char(CH_ZERO, 1'b0);
        end else begin
            if (ex >= EXP_SAT) begin
                // 2^31 and up: saturated integer, no fraction bits left
                ovf   = 1'b1;
                ipart = INT_SAT;
            end else begin
                if (ex == 8'd0) begin
                    mant = {41'd0, man};
                    e    = -int'(SUBN_SHIFT);
                end else begin
                    mant = {40'd0, 1'b1, man};
                    e    = int'(ex) - int'(EXP_INT);
                end
                if (e >= 0) begin
                    ipart = 32'(mant << e);
                end else begin
                    sh    = -e;
                    rem   = (sh >= MAN_W) ? mant : (mant & ((64'd1 << sh) - 64'd1));
                    ipart = (sh >= MAN_W) ? 32'd0 : 32'(mant >> sh);
                    // shifts past the width give zero, as intended for tiny values
                    frac  = (sh <= FRAC_W) ? (rem << (FRAC_W - sh)) : (rem >> (sh - FRAC_W));
                end
            end
            prec = (int'(precision) > MAX_PRECISION) ? MAX_PRECISION : int'(precision);
            if (neg) push_char(CH_MINUS, ovf);
            while (ipart != 0) begin
                dig[nd] = 4'(ipart % 10);
                ipart   = ipart / 10;
                nd++;
            end
            for (int j = nd - 1; j >= 0; j--) push_char(CH_ZERO + 8'(dig[j]), ovf);
            push_char(CH_DOT, ovf);
            // truncated fraction digits, one multiply by ten each
            for (int j = 0; j < prec; j++) begin
                prod = frac * 64'd10;
                d    = prod >> FRAC_W;
                if (d > 64'd9) d = 64'd9;
                frac = prod & 64'hFFFF_FFFF;
                push_char(CH_ZERO + 8'(d), ovf);
            end
        end
        expected_text[expected_text.size() - 1].is_last = 1'b1;
    endfunction

    // Track precision, predict on each accepted number, check each character
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_text.delete();
            precision = PREC_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) precision = i_cfg_data;
            if (i_start && !i_busy) predict_text(i_value_bits);
            if (i_char_valid) begin
                if (expected_text.size() == 0) begin
                    $error("text_char: none expected, got %h", i_text_char);
                    fail_count++;
                end else begin
                    got_word = expected_text.pop_front();
                    if (i_text_char !== got_word.ch) begin
                        $error("text_char: expected %h, got %h", got_word.ch, i_text_char);
                        fail_count++;
                    end
                    if (i_last_char !== got_word.is_last) begin
                        $error("last_char: expected %b, got %b", got_word.is_last,
                               i_last_char);
                        fail_count++;
                    end
                    if (i_overflow !== got_word.ovf) begin
                        $error("overflow: expected %b, got %b", got_word.ovf, i_overflow);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_text.size();
    end

endmodule

[verif/tb_float_to_decimal_text_top.sv]
// tb_float_to_decimal_text_top: drives numbers and precision writes into
// float_to_decimal_text_top and gives the verdict; checking is done by ftdt_text_checker.
// Depends on ftdt_pkg, float_to_decimal_text_top and ftdt_text_checker.
`timescale 1ns / 1ps

module tb_float_to_decimal_text_top;
    import ftdt_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_PREC      = 11;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 45;
    localparam int MAX_GAP       = 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int N_DIRECTED    = 20;
    localparam int IDLE_PCT[3]   = '{0, 47, 25};
    // precision per random phase; the last phase draws its own
    localparam logic [PREC_W-1:0] PREC_PLAN[PHASES] = '{0, 11, 15, 1, 12, 9, 3, 8};

    // zeros, infinities, NaNs, subnormal and saturation edges, ordinary values
    localparam logic [31:0] DIRECTED[N_DIRECTED] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h3F80_0000,
        32'hBF00_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
        32'h4F00_0000, 32'hCEFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
        32'h4B7F_FFFF, 32'h3DCC_CCCD, 32'h42F6_E979, 32'h3F7F_FFFF
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [31:0]       i_value_bits = '0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PREC_W-1:0] i_cfg_data = '0;
    logic              o_char_valid;
    logic [7:0]        o_text_char;
    logic              o_last_char;
    logic              o_overflow;
    int                fail_count;
    int                pending;
    int                stall_cycles = 0;
    int                numbers_sent = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    float_to_decimal_text_top #(
        .FRACTION_BITS(32),
        .MAX_PRECISION(MAX_PREC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value_bits(i_value_bits),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_char_valid(o_char_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char),
        .o_overflow  (o_overflow)
    );

    ftdt_text_checker #(
        .MAX_PRECISION(MAX_PREC)
    ) u_text_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_value_bits(i_value_bits),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_char_valid(o_char_valid),
        .i_text_char (o_text_char),
        .i_last_char (o_last_char),
        .i_overflow  (o_overflow),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Watchdog: cycles in a row with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_char_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly the formatting range, with specials, subnormals and saturation mixed in
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(99);
        v    = $urandom();
        if (pick < 10) begin
            // raw bit pattern
        end else if (pick < 16) begin
            v[30:23] = EXP_SPECIAL;
            if (pick < 12) v[22:0] = '0;
        end else if (pick < 22) begin
            v[30:23] = 8'd0;
            if (pick < 18) v[22:0] = '0;
        end else if (pick < 32) begin
            v[30:23] = 8'($urandom_range(158, 254));
        end else begin
            v[30:23] = 8'($urandom_range(96, 157));
        end
        return v;
    endfunction

    // Offer one number; returns at the edge that accepted it, start still high
    task automatic send_number(input logic [31:0] bits, input int idle_pct);
        int   gap;
        logic taken;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(MAX_GAP, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_value_bits <= bits;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        numbers_sent++;
    endtask

    // Block idle: nothing owed by the checker and not busy
    task automatic wait_drained();
        forever begin
            @(negedge i_clk);
            if (pending == 0 && !busy) break;
        end
        @(posedge i_clk);
    endtask

    task automatic write_precision(input logic [PREC_W-1:0] prec);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= prec;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [PREC_W-1:0] prec;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed numbers at the reset precision, back to back
        for (int n = 0; n < N_DIRECTED; n++) send_number(DIRECTED[n], 0);
        start <= 1'b0;

        // random phases, each with its own precision and sender idling
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            prec = (phase == PHASES - 1) ? PREC_W'($urandom_range(15)) : PREC_PLAN[phase];
            write_precision(prec);
            for (int n = 0; n < PHASE_ITEMS; n++) send_number(random_value(), IDLE_PCT[phase % 3]);
            start <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d numbers (%0d directed) over %0d precision writes plus reset.",
                 numbers_sent, N_DIRECTED, PHASES);
        $display("Sender gaps at 0, 25 and 47 percent; the character channel never stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[float_to_decimal_text_top.f]
sv/ftdt_pkg.sv
sv/ftdt_datapath.sv
sv/ftdt_ctrl.sv
sv/float_to_decimal_text_top.sv
verif/ftdt_text_checker.sv
verif/tb_float_to_decimal_text_top.sv
